// ===== rtl/bts_pkg.sv =====
// Shared types, sizes and constants of the bilinear texture sampler.
// Every other file of the block imports this package; it depends on nothing.
`default_nettype none

package bts_pkg;

  // Texel store size; the depth is taken to be a power of two, so addresses wrap
  // by truncation.
  localparam int TEXEL_COUNT   = 4096;
  localparam int ADDR_W        = $clog2(TEXEL_COUNT);
  // Fractional bits of the incoming coordinates.
  localparam int FRACTION_BITS = 16;

  localparam int DIM_W      = 13;
  localparam int WEIGHT_W   = 16;
  localparam int CH_W       = 8;
  localparam int TEXEL_W    = 24;
  localparam int OUT_W      = 16;
  localparam int IDX_W      = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Depth of the queue between front and back.
  localparam int QDEPTH = 4;

  // Fifth root is resolved one bit per step, four register stages per step.
  localparam int ROOT_BITS = 16;
  localparam int DEC_LAT   = 3 + 4 * ROOT_BITS + 2;

  // Constant dividers done by reciprocal multiply and one correction.
  localparam int S_Q_W    = 26;
  localparam int S_DIV    = 255;
  localparam longint unsigned S_RECIP = (64'd1 << S_Q_W) / S_DIV;
  localparam int LIN_Q_W  = 20;
  localparam int LIN_DIV  = 1292;
  localparam longint unsigned LIN_RECIP = (64'd1 << LIN_Q_W) / LIN_DIV;
  localparam int PW_Q_W   = 27;
  localparam int PW_DIV   = 1055;
  localparam longint unsigned PW_RECIP = (64'd1 << PW_Q_W) / PW_DIV;

  typedef logic [DIM_W-1:0]    dim_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [TEXEL_W-1:0]  texel_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  // What the back part does with a queued beat.
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t   kind;
    addr_t   addr00;
    addr_t   addr10;
    addr_t   addr01;
    addr_t   addr11;
    weight_t tx;
    weight_t ty;
    texel_t  texel;
  } qent_t;

endpackage

`default_nettype wire

// ===== rtl/bts_if.sv =====
// Handshake interfaces of the sampler: request, result and configuration.
// Depends on bts_pkg for field widths.
`default_nettype none

interface bts_in_if;
  import bts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [31:0]       u_coord;
  logic signed [31:0]       v_coord;
  logic [IDX_W-1:0]         texel_index;
  logic [CH_W-1:0]          texel_red;
  logic [CH_W-1:0]          texel_green;
  logic [CH_W-1:0]          texel_blue;
  modport source (output valid, opcode, u_coord, v_coord, texel_index,
                  texel_red, texel_green, texel_blue, input ready);
  modport sink (input valid, opcode, u_coord, v_coord, texel_index,
                texel_red, texel_green, texel_blue, output ready);
endinterface

interface bts_out_if;
  import bts_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_linear;
  logic [OUT_W-1:0] green_linear;
  logic [OUT_W-1:0] blue_linear;
  logic             was_empty;
  modport source (output valid, red_linear, green_linear, blue_linear, was_empty,
                  input ready);
  modport sink (input valid, red_linear, green_linear, blue_linear, was_empty,
                output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bts_ram.sv =====
// One-write one-read texel memory with registered read data.
// Depends on bts_pkg for depth and width.
`default_nettype none

module bts_ram (
  input  logic            clk,
  input  logic            we,
  input  bts_pkg::addr_t  waddr,
  input  bts_pkg::texel_t wdata,
  input  logic            re,
  input  bts_pkg::addr_t  raddr,
  output bts_pkg::texel_t rdata
);
  import bts_pkg::*;

  texel_t mem [TEXEL_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while the read enable is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bts_queue.sv =====
// Short queue that decouples the front part from the back part.
// Depends on bts_pkg for the entry type and depth.
`default_nettype none

module bts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bts_pkg::qent_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bts_pkg::qent_t pop_data
);
  import bts_pkg::*;

  localparam int QP_W = $clog2(QDEPTH);

  qent_t           mem [QDEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != (QP_W+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bts_front.sv =====
// Front part: accepts beats, wraps and splits coordinates, forms texel addresses.
// Depends on bts_pkg and the bts_in_if interface.
`default_nettype none

module bts_front (
  input  logic           clk,
  input  logic           rst,
  bts_in_if.sink         req,
  input  bts_pkg::dim_t  tex_width,
  input  bts_pkg::dim_t  tex_height,
  output logic           q_valid,
  input  logic           q_ready,
  output bts_pkg::qent_t q_data
);
  import bts_pkg::*;

  localparam int F = FRACTION_BITS;

  logic en;

  logic           f1_vld, f1_op, f1_emp;
  logic [F-1:0]   f1_uf;
  logic [F:0]     f1_vf;
  logic [IDX_W-1:0] f1_idx;
  texel_t         f1_texel;

  logic           f2_vld, f2_op, f2_emp;
  dim_t           f2_x0, f2_y0;
  weight_t        f2_tx, f2_ty;
  logic [IDX_W-1:0] f2_idx;
  texel_t         f2_texel;

  logic           f3_vld, f3_op, f3_emp;
  dim_t           f3_x0, f3_x1;
  logic [2*DIM_W-1:0] f3_row0, f3_row1;
  weight_t        f3_tx, f3_ty;
  logic [IDX_W-1:0] f3_idx;
  texel_t         f3_texel;

  logic           f4_vld;
  qent_t          f4_ent;

  logic [F+DIM_W-1:0]  pu;
  logic [F+DIM_W:0]    pv;
  logic [F+15:0]       wu, wv;
  logic [DIM_W:0]      xp, yp;
  dim_t                x1, y1;
  logic [31:0]         a00, a10, a01, a11, widx;

  // The whole front advances unless its last stage holds a beat the queue refuses.
  assign en        = !f4_vld || q_ready;
  assign req.ready = en;
  assign q_valid   = f4_vld;
  assign q_data    = f4_ent;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
      f4_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= req.valid;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
      f4_vld <= f3_vld;
    end
  end

  // Capture the beat; keep only the coordinate fractions and flip v.
  always_ff @(posedge clk) begin
    if (en) begin
      f1_op    <= req.opcode;
      f1_emp   <= (tex_width == '0) || (tex_height == '0);
      f1_uf    <= req.u_coord[F-1:0];
      f1_vf    <= ((F+1)'(1) << F) - {1'b0, req.v_coord[F-1:0]};
      f1_idx   <= req.texel_index;
      f1_texel <= {req.texel_blue, req.texel_green, req.texel_red};
    end
  end

  // Scale by size minus one, then split into position and weight.
  always_comb begin
    pu = (F+DIM_W)'(f1_uf) * (F+DIM_W)'(tex_width - 1'b1);
    pv = (F+DIM_W+1)'(f1_vf) * (F+DIM_W+1)'(tex_height - 1'b1);
    wu = {pu[F-1:0], 16'b0};
    wv = {pv[F-1:0], 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_op    <= f1_op;
      f2_emp   <= f1_emp;
      f2_x0    <= pu[F +: DIM_W];
      f2_y0    <= pv[F +: DIM_W];
      f2_tx    <= wu[F +: WEIGHT_W];
      f2_ty    <= wv[F +: WEIGHT_W];
      f2_idx   <= f1_idx;
      f2_texel <= f1_texel;
    end
  end

  // Clamp the neighbors at the last column and row, and form row offsets.
  always_comb begin
    xp = (DIM_W+1)'(f2_x0) + 1'b1;
    yp = (DIM_W+1)'(f2_y0) + 1'b1;
    x1 = (xp < (DIM_W+1)'(tex_width))  ? xp[DIM_W-1:0] : tex_width - 1'b1;
    y1 = (yp < (DIM_W+1)'(tex_height)) ? yp[DIM_W-1:0] : tex_height - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_op    <= f2_op;
      f3_emp   <= f2_emp;
      f3_x0    <= f2_x0;
      f3_x1    <= x1;
      f3_row0  <= (2*DIM_W)'(f2_y0) * (2*DIM_W)'(tex_width);
      f3_row1  <= (2*DIM_W)'(y1) * (2*DIM_W)'(tex_width);
      f3_tx    <= f2_tx;
      f3_ty    <= f2_ty;
      f3_idx   <= f2_idx;
      f3_texel <= f2_texel;
    end
  end

  // Final addresses, wrapped to the store depth.
  always_comb begin
    a00  = 32'(f3_row0) + 32'(f3_x0);
    a10  = 32'(f3_row0) + 32'(f3_x1);
    a01  = 32'(f3_row1) + 32'(f3_x0);
    a11  = 32'(f3_row1) + 32'(f3_x1);
    widx = 32'(f3_idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_ent.texel <= f3_texel;
      f4_ent.tx    <= f3_tx;
      f4_ent.ty    <= f3_ty;
      f4_ent.addr10 <= a10[ADDR_W-1:0];
      f4_ent.addr01 <= a01[ADDR_W-1:0];
      f4_ent.addr11 <= a11[ADDR_W-1:0];
      if (!f3_op) begin
        f4_ent.kind   <= KIND_WRITE;
        f4_ent.addr00 <= widx[ADDR_W-1:0];
      end else begin
        f4_ent.kind   <= f3_emp ? KIND_EMPTY : KIND_SAMPLE;
        f4_ent.addr00 <= a00[ADDR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bts_decode.sv =====
// sRGB to linear decode of one channel, fully pipelined with a bit-serial fifth root.
// Depends on bts_pkg for latency and divider constants.
`default_nettype none

module bts_decode (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] s,
  output logic [15:0] lin_out
);
  import bts_pkg::*;

  localparam int LAST = ROOT_BITS - 1;

  logic [39:0]          lin_n;
  logic [LIN_Q_W-1:0]   lq;
  logic [39:0]          lin_p;
  logic [PW_Q_W:0]      pw_n;
  logic [PW_Q_W-1:0]    pq;
  logic [55:0]          pw_p;

  logic                 d1_sel;
  logic [LIN_Q_W-1:0]   d1_lq, d1_le;
  logic [PW_Q_W-1:0]    d1_pq, d1_pe;

  logic [31:0]          lin_rem, pw_rem;
  logic                 d2_sel;
  logic [15:0]          d2_lin;
  logic [16:0]          d2_t;

  logic [33:0]          tt;
  logic                 d3_sel;
  logic [15:0]          d3_lin;
  logic [16:0]          d3_t2;

  logic [ROOT_BITS-1:0] sd_r   [ROOT_BITS];
  logic [16:0]          sd_y   [ROOT_BITS];
  logic [15:0]          sd_lin [ROOT_BITS];
  logic                 sd_sel [ROOT_BITS];

  logic [16:0]          rr;
  logic                 p1_sel;
  logic [15:0]          p1_lin;
  logic [33:0]          p1_prod;
  logic [49:0]          pv;
  logic [17:0]          po;

  // Linear segment and power segment dividends, with reciprocal estimates.
  always_comb begin
    lin_n = 40'(s) * 40'd6553500 + 40'd42336256;
    lq    = lin_n[16 +: LIN_Q_W];
    lin_p = 40'(lq) * 40'(LIN_RECIP);
    pw_n  = (PW_Q_W+1)'(s) * (PW_Q_W+1)'(1000) + (PW_Q_W+1)'(3605007);
    pq    = pw_n[PW_Q_W-1:0];
    pw_p  = 56'(pq) * 56'(PW_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_sel <= (38'(s) * 38'd100000) <= 38'(4045 * 65536);
      d1_lq  <= lq;
      d1_le  <= lin_p[LIN_Q_W +: LIN_Q_W];
      d1_pq  <= pq;
      d1_pe  <= pw_p[PW_Q_W +: PW_Q_W];
    end
  end

  // One correction step finishes each division.
  always_comb begin
    lin_rem = 32'(d1_lq) - 32'(d1_le) * 32'(LIN_DIV);
    pw_rem  = 32'(d1_pq) - 32'(d1_pe) * 32'(PW_DIV);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_sel <= d1_sel;
      d2_lin <= 16'(d1_le + LIN_Q_W'(lin_rem >= 32'(LIN_DIV)));
      d2_t   <= 17'(d1_pe + PW_Q_W'(pw_rem >= 32'(PW_DIV)));
    end
  end

  // Square with rounding back to Q.16.
  assign tt = 34'(d2_t) * 34'(d2_t) + 34'd32768;

  always_ff @(posedge clk) begin
    if (en) begin
      d3_sel <= d2_sel;
      d3_lin <= d2_lin;
      d3_t2  <= tt[32:16];
    end
  end

  // Fifth root, most significant bit first: keep a bit while cand^5 <= y * 2^64.
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    logic [ROOT_BITS-1:0] r_in;
    logic [16:0]          y_in;
    logic [15:0]          lin_in;
    logic                 sel_in;
    logic [ROOT_BITS-1:0] cand;
    logic [ROOT_BITS-1:0] sa_c, sa_r, sb_c, sb_r, sc_r;
    logic [2*ROOT_BITS-1:0] sa_c2;
    logic [63:0]          sb_c4;
    logic [47:0]          sc_lo, sc_hi;
    logic [16:0]          sa_y, sb_y, sc_y;
    logic [15:0]          sa_lin, sb_lin, sc_lin;
    logic                 sa_sel, sb_sel, sc_sel;
    logic [ROOT_BITS-1:0] sc_c;
    logic [79:0]          r5;

    if (k == 0) begin : g_first
      assign r_in   = '0;
      assign y_in   = d3_t2;
      assign lin_in = d3_lin;
      assign sel_in = d3_sel;
    end else begin : g_next
      assign r_in   = sd_r[k-1];
      assign y_in   = sd_y[k-1];
      assign lin_in = sd_lin[k-1];
      assign sel_in = sd_sel[k-1];
    end

    assign cand = r_in | (ROOT_BITS'(1) << (ROOT_BITS - 1 - k));
    assign r5   = {sc_hi, 32'b0} + 80'(sc_lo);

    always_ff @(posedge clk) begin
      if (en) begin
        sa_c   <= cand;
        sa_c2  <= (2*ROOT_BITS)'(cand) * (2*ROOT_BITS)'(cand);
        sa_r   <= r_in;
        sa_y   <= y_in;
        sa_lin <= lin_in;
        sa_sel <= sel_in;

        sb_c   <= sa_c;
        sb_c4  <= 64'(sa_c2) * 64'(sa_c2);
        sb_r   <= sa_r;
        sb_y   <= sa_y;
        sb_lin <= sa_lin;
        sb_sel <= sa_sel;

        sc_c   <= sb_c;
        sc_lo  <= 48'(sb_c4[31:0]) * 48'(sb_c);
        sc_hi  <= 48'(sb_c4[63:32]) * 48'(sb_c);
        sc_r   <= sb_r;
        sc_y   <= sb_y;
        sc_lin <= sb_lin;
        sc_sel <= sb_sel;

        sd_r[k]   <= (81'(r5) <= {sc_y, 64'b0}) ? sc_c : sc_r;
        sd_y[k]   <= sc_y;
        sd_lin[k] <= sc_lin;
        sd_sel[k] <= sc_sel;
      end
    end
  end

  // A full-scale input has a root of exactly one.
  assign rr = (sd_y[LAST] >= 17'h10000) ? 17'h10000 : 17'(sd_r[LAST]);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sel  <= sd_sel[LAST];
      p1_lin  <= sd_lin[LAST];
      p1_prod <= 34'(sd_y[LAST]) * 34'(rr);
    end
  end

  // Scale by 65535 with rounding, saturate, and pick the segment.
  always_comb begin
    pv = {p1_prod, 16'b0} - 50'(p1_prod) + (50'd1 << 31);
    po = pv[49:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p1_sel) begin
        lin_out <= p1_lin;
      end else begin
        lin_out <= (po > 18'd65535) ? 16'hFFFF : po[15:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bts_back.sv =====
// Back part: texel store, four-texel fetch, bilinear blend and sRGB decode.
// Depends on bts_pkg, bts_out_if, bts_ram and bts_decode.
`default_nettype none

module bts_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  bts_pkg::qent_t q_data,
  bts_out_if.source      rsp
);
  import bts_pkg::*;

  logic    en;
  logic    pop;
  logic    we;
  addr_t   raddr [4];
  texel_t  rd    [4];

  logic    b0_vld, b0_emp, b1_vld, b1_emp, b2_vld, b2_emp;
  logic    b3_vld, b3_emp, b4_vld, b4_emp;
  weight_t b0_tx, b0_ty, b1_ty;
  logic [16:0] itx, ity;
  logic [24:0] b1_top [3];
  logic [24:0] b1_bot [3];
  logic [41:0] b2_bl  [3];
  logic [S_Q_W-1:0] b3_q [3];
  logic [S_Q_W-1:0] b3_e [3];
  logic [16:0] b4_s   [3];
  logic [15:0] dec    [3];

  logic [DEC_LAT-1:0] ln_vld, ln_emp;

  // The back advances unless a result is waiting to be taken.
  assign en      = !rsp.valid || rsp.ready;
  assign pop     = q_valid && en;
  assign q_ready = en;
  assign we      = pop && (q_data.kind == KIND_WRITE);

  assign raddr[0] = q_data.addr00;
  assign raddr[1] = q_data.addr10;
  assign raddr[2] = q_data.addr01;
  assign raddr[3] = q_data.addr11;

  // Four copies of the store, one read port for each corner texel.
  for (genvar i = 0; i < 4; i++) begin : g_ram
    bts_ram u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (q_data.addr00),
      .wdata (q_data.texel),
      .re    (en),
      .raddr (raddr[i]),
      .rdata (rd[i])
    );
  end

  // Valid and empty flags beside the data path.
  always_ff @(posedge clk) begin
    if (rst) begin
      b0_vld <= 1'b0;
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
      b3_vld <= 1'b0;
      b4_vld <= 1'b0;
      ln_vld <= '0;
    end else if (en) begin
      b0_vld <= pop && (q_data.kind != KIND_WRITE);
      b1_vld <= b0_vld;
      b2_vld <= b1_vld;
      b3_vld <= b2_vld;
      b4_vld <= b3_vld;
      ln_vld <= {ln_vld[DEC_LAT-2:0], b4_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_emp <= (q_data.kind == KIND_EMPTY);
      b1_emp <= b0_emp;
      b2_emp <= b1_emp;
      b3_emp <= b2_emp;
      b4_emp <= b3_emp;
      ln_emp <= {ln_emp[DEC_LAT-2:0], b4_emp};
      b0_tx  <= q_data.tx;
      b0_ty  <= q_data.ty;
      b1_ty  <= b0_ty;
    end
  end

  assign itx = 17'h10000 - 17'(b0_tx);
  assign ity = 17'h10000 - 17'(b1_ty);

  // Blend along x, then along y, then divide by 255 * 2^16 with rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        b1_top[ch] <= 25'(rd[0][ch*CH_W +: CH_W]) * 25'(itx)
                    + 25'(rd[1][ch*CH_W +: CH_W]) * 25'(b0_tx);
        b1_bot[ch] <= 25'(rd[2][ch*CH_W +: CH_W]) * 25'(itx)
                    + 25'(rd[3][ch*CH_W +: CH_W]) * 25'(b0_tx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        b2_bl[ch] <= 42'(b1_top[ch]) * 42'(ity) + 42'(b1_bot[ch]) * 42'(b1_ty);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [41:0] x;
    logic [51:0] p;
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        x = b2_bl[ch] + 42'(255 * 32768);
        p = 52'(x[16 +: S_Q_W]) * 52'(S_RECIP);
        b3_q[ch] <= x[16 +: S_Q_W];
        b3_e[ch] <= p[S_Q_W +: S_Q_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] rem;
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem = 34'(b3_q[ch]) - 34'(b3_e[ch]) * 34'(S_DIV);
        b4_s[ch] <= 17'(b3_e[ch] + S_Q_W'(rem >= 34'(S_DIV)));
      end
    end
  end

  // Per-channel curve decode.
  for (genvar ch = 0; ch < 3; ch++) begin : g_dec
    bts_decode u_dec (
      .clk     (clk),
      .en      (en),
      .s       (b4_s[ch]),
      .lin_out (dec[ch])
    );
  end

  // Result; an empty texture reads as white.
  assign rsp.valid        = ln_vld[DEC_LAT-1];
  assign rsp.was_empty    = ln_emp[DEC_LAT-1];
  assign rsp.red_linear   = ln_emp[DEC_LAT-1] ? 16'hFFFF : dec[0];
  assign rsp.green_linear = ln_emp[DEC_LAT-1] ? 16'hFFFF : dec[1];
  assign rsp.blue_linear  = ln_emp[DEC_LAT-1] ? 16'hFFFF : dec[2];

endmodule

`default_nettype wire

// ===== rtl/bilinear_texture_sampler_unit.sv =====
// Top level of the bilinear texture sampler: configuration registers and the
// front, queue and back parts. Depends on bts_pkg, the interfaces and all submodules.
`default_nettype none

// The sampler takes one beat per clock, write or sample, while its request ready
// is high, and gives one result per clock for samples while the result side keeps
// ready high. Writes fill the texel store and return nothing; texel entries hold
// no value until written. A sample result passes 79 register stages when nothing
// stalls: four front stages, one queue entry, five fetch and blend stages and 69
// decode stages, of which the bit-per-step fifth root of the sRGB curve takes 64.
// The store is kept in four copies, so the four corner texels are read in the same
// cycle. A stalled result freezes the back part; the queue then lets the front
// take a few more beats before ready drops. The store depth is a power of two
// and addresses wrap at it. The user must write configuration only while the
// block idles; the block itself does not enforce it.
module bilinear_texture_sampler_unit (
  input  logic    clk,
  input  logic    rst,
  bts_in_if.sink  req,
  bts_out_if.source rsp,
  bts_cfg_if.sink cfg
);
  import bts_pkg::*;

  dim_t  tex_width;
  dim_t  tex_height;
  logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  qent_t q_push_data, q_pop_data;

  assign cfg.ready = 1'b1;

  // Configuration registers; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= '0;
      tex_height <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WIDTH:  tex_width  <= cfg.data[DIM_W-1:0];
        CFG_HEIGHT: tex_height <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  bts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .tex_width  (tex_width),
    .tex_height (tex_height),
    .q_valid    (q_push_valid),
    .q_ready    (q_push_ready),
    .q_data     (q_push_data)
  );

  bts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  bts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_pop_valid),
    .q_ready (q_pop_ready),
    .q_data  (q_pop_data),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for bilinear_texture_sampler_unit: samples the empty texture,
// fills the low texels, then runs directed and random beats under many texture sizes.
// Depends on bts_pkg, the bts interfaces and the sampler RTL.

module testbench;
  import bts_pkg::*;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam int   DRAIN_CYCLES = 120;
  localparam int   FILL_COUNT   = 256;

  typedef struct {
    logic        op;
    logic [31:0] u;
    logic [31:0] v;
    logic [11:0] idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } req_t;

  typedef struct {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic        empty;
  } pix_t;

  typedef struct {
    req_t rq;
    bit   typed;
    pix_t want;
  } row_t;

  typedef struct {
    logic [15:0] w;
    logic [15:0] h;
    int          count;
    bit          hold;
    bit          pause;
    bit          calm;
  } phase_t;

  logic clk;
  logic rst;

  bts_in_if  req_bus ();
  bts_out_if rsp_bus ();
  bts_cfg_if cfg_bus ();

  bilinear_texture_sampler_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  // Shadow of the texture and of the size registers.
  logic [23:0] texel_mirror [TEXEL_COUNT];
  bit          texel_written [TEXEL_COUNT];
  logic [12:0] mirror_w;
  logic [12:0] mirror_h;
  pix_t        pending_pix [$];
  int          error_count;
  bit          quiet;
  bit          long_hold_req;

  // Floor of the fifth root of a Q.16 value, in Q.16.
  function automatic longint unsigned fifth_root(longint unsigned y);
    longint unsigned lo, hi, mid;
    logic [127:0]    pw, tgt;
    if (y >= 65536) return 65536;
    lo = 0;
    hi = 65535;
    tgt = 128'(y) << 64;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      pw = 128'(mid) * mid * mid * mid * mid;
      if (pw <= tgt) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Piecewise sRGB decode of one blended channel.
  function automatic logic [15:0] srgb_decode(longint unsigned blend);
    longint unsigned s, t, t2, rt, lin;
    s = (blend + 64'd255 * 64'd32768) / (64'd255 * 64'd65536);
    if (s * 100000 <= 64'd4045 * 64'd65536)
      return 16'((s * 6553500 + (64'd65536 * 64'd1292) / 2) / (64'd65536 * 64'd1292));
    t = (s * 1000 + 64'd55 * 64'd65536 + 527) / 1055;
    t2 = (t * t + 32768) >> 16;
    rt = fifth_root(t2);
    lin = (t2 * rt * 65535 + (64'd1 << 31)) >> 32;
    return (lin > 65535) ? 16'hFFFF : 16'(lin);
  endfunction

  function automatic logic [23:0] texel_at(longint unsigned x, longint unsigned y);
    longint unsigned a;
    a = y * mirror_w + x;
    return texel_mirror[a[11:0]];
  endfunction

  function automatic bit written_at(longint unsigned x, longint unsigned y);
    longint unsigned a;
    a = y * mirror_w + x;
    return texel_written[a[11:0]];
  endfunction

  // True when a beat touches only texels that have been written.
  function automatic bit sample_ok(req_t rq);
    longint unsigned fu, fv, x0, y0, x1, y1, w, h;
    if (rq.op == OP_WRITE || mirror_w == 0 || mirror_h == 0) return 1'b1;
    w = mirror_w;
    h = mirror_h;
    fu = rq.u[15:0];
    fv = 65536 - rq.v[15:0];
    x0 = (fu * (w - 1)) >> 16;
    y0 = (fv * (h - 1)) >> 16;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    return written_at(x0, y0) && written_at(x1, y0) &&
           written_at(x0, y1) && written_at(x1, y1);
  endfunction

  // Expected pixel of a sample beat under the current texture.
  function automatic pix_t sample_pixel(req_t rq);
    pix_t            p;
    longint unsigned fu, fv, px, py, x0, y0, x1, y1, tx, ty, w, h;
    longint unsigned ca, cb, cc, cd, top, bot;
    logic [23:0]     t00, t10, t01, t11;
    if (mirror_w == 0 || mirror_h == 0) begin
      p = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
      return p;
    end
    w = mirror_w;
    h = mirror_h;
    fu = rq.u[15:0];
    fv = 65536 - rq.v[15:0];
    px = fu * (w - 1);
    py = fv * (h - 1);
    x0 = px >> 16;
    y0 = py >> 16;
    tx = px & 64'hFFFF;
    ty = py & 64'hFFFF;
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    t00 = texel_at(x0, y0);
    t10 = texel_at(x1, y0);
    t01 = texel_at(x0, y1);
    t11 = texel_at(x1, y1);
    for (int ch = 0; ch < 3; ch++) begin
      ca = t00[ch*8 +: 8];
      cb = t10[ch*8 +: 8];
      cc = t01[ch*8 +: 8];
      cd = t11[ch*8 +: 8];
      top = ca * (65536 - tx) + cb * tx;
      bot = cc * (65536 - tx) + cd * tx;
      case (ch)
        0: p.r = srgb_decode(top * (65536 - ty) + bot * ty);
        1: p.g = srgb_decode(top * (65536 - ty) + bot * ty);
        default: p.b = srgb_decode(top * (65536 - ty) + bot * ty);
      endcase
    end
    p.empty = 1'b0;
    return p;
  endfunction

  // Clock and the single reset.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one beat, wait for it to be taken, then record what it should do.
  task automatic send_beat(req_t rq, bit typed, pix_t want);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req_bus.opcode      = rq.op;
    req_bus.u_coord     = rq.u;
    req_bus.v_coord     = rq.v;
    req_bus.texel_index = rq.idx;
    req_bus.texel_red   = rq.r;
    req_bus.texel_green = rq.g;
    req_bus.texel_blue  = rq.b;
    req_bus.valid       = 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    if (rq.op == OP_WRITE) begin
      texel_mirror[rq.idx]  = {rq.b, rq.g, rq.r};
      texel_written[rq.idx] = 1'b1;
    end else begin
      pending_pix.push_back(typed ? want : sample_pixel(rq));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
  endtask

  // Register write, only once the pipeline has gone quiet.
  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_WIDTH) mirror_w = data[12:0];
    else if (idx == CFG_HEIGHT) mirror_h = data[12:0];
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return {16'($urandom), 16'h0000};
      1: return {16'($urandom), 16'hFFFF};
      2: return {16'($urandom), 16'h8000};
      3: return {16'($urandom), 16'h0001};
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_beat(int write_pct);
    req_t rq;
    rq.op  = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_SAMPLE;
    rq.u   = pick_coord();
    rq.v   = pick_coord();
    rq.idx = 12'($urandom);
    rq.r   = 8'($urandom);
    rq.g   = 8'($urandom);
    rq.b   = 8'($urandom);
    return rq;
  endfunction

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_bus.ready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (!quiet && !rst && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        rsp_bus.ready = !rst;
      end
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    pix_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_pix.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result r=%h g=%h b=%h empty=%b", $realtime,
                 rsp_bus.red_linear, rsp_bus.green_linear, rsp_bus.blue_linear,
                 rsp_bus.was_empty);
      end else begin
        want = pending_pix.pop_front();
        if (rsp_bus.red_linear !== want.r) begin
          error_count++;
          $display("%0t: red expected %h got %h", $realtime, want.r, rsp_bus.red_linear);
        end
        if (rsp_bus.green_linear !== want.g) begin
          error_count++;
          $display("%0t: green expected %h got %h", $realtime, want.g,
                   rsp_bus.green_linear);
        end
        if (rsp_bus.blue_linear !== want.b) begin
          error_count++;
          $display("%0t: blue expected %h got %h", $realtime, want.b, rsp_bus.blue_linear);
        end
        if (rsp_bus.was_empty !== want.empty) begin
          error_count++;
          $display("%0t: was_empty expected %b got %b", $realtime, want.empty,
                   rsp_bus.was_empty);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    row_t   dir_rows [$];
    phase_t phases [$];
    req_t   rq;
    pix_t   white;
    pix_t   none;
    int     fill_order [FILL_COUNT];
    int     tmp, k;

    error_count   = 0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    mirror_w      = '0;
    mirror_h      = '0;
    req_bus.valid = 1'b0;
    req_bus.opcode = OP_WRITE;
    req_bus.u_coord = '0;
    req_bus.v_coord = '0;
    req_bus.texel_index = '0;
    req_bus.texel_red = '0;
    req_bus.texel_green = '0;
    req_bus.texel_blue = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    white = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
    none  = '{16'h0, 16'h0, 16'h0, 1'b0};

    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows: empty texture after reset, then corners of a 4x4 texture.
    dir_rows.push_back('{'{OP_SAMPLE, 32'h0, 32'h0, 12'h0, 8'h0, 8'h0, 8'h0}, 1, white});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h7FFFFFFF, 32'h80000000, 12'hFFF, 8'hFF, 8'hFF,
                          8'hFF}, 1, white});
    dir_rows.push_back('{'{OP_SAMPLE, 32'hFFFFFFFF, 32'h7FFFFFFF, 12'h0, 8'h0, 8'h0, 8'h0},
                         1, white});
    foreach (dir_rows[i]) send_beat(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    dir_rows.delete();

    // Fill the low texels once, in shuffled order; samples later stay on written texels.
    for (int i = 0; i < FILL_COUNT; i++) fill_order[i] = i;
    for (int i = FILL_COUNT - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[k];
      fill_order[k] = tmp;
    end
    for (int i = 0; i < FILL_COUNT; i++) begin
      rq = random_beat(100);
      rq.idx = 12'(fill_order[i]);
      if (i % 7 == 0) {rq.r, rq.g, rq.b} = '0;
      if (i % 11 == 0) {rq.r, rq.g, rq.b} = '1;
      send_beat(rq, 0, none);
    end

    write_reg(CFG_WIDTH, 16'd4);
    write_reg(CFG_HEIGHT, 16'd4);
    dir_rows.push_back('{'{OP_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, 12'd0, 8'h00, 8'h00, 8'h00},
                         0, none});
    dir_rows.push_back('{'{OP_WRITE, 32'h0, 32'h0, 12'd15, 8'hFF, 8'hFF, 8'hFF}, 0, none});
    dir_rows.push_back('{'{OP_WRITE, 32'h0, 32'h0, 12'd12, 8'hFF, 8'h00, 8'h80}, 0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h0, 32'h0, 12'hFFF, 8'hFF, 8'hFF, 8'hFF}, 0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h0, 32'h0000FFFF, 12'h0, 8'h0, 8'h0, 8'h0}, 0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h0000FFFF, 32'h0000FFFF, 12'h0, 8'h0, 8'h0, 8'h0},
                         0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h7FFFFFFF, 32'h80000000, 12'h0, 8'h0, 8'h0, 8'h0},
                         0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h80000000, 32'h7FFFFFFF, 12'h0, 8'h0, 8'h0, 8'h0},
                         0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'hFFFF8000, 32'h00018000, 12'h0, 8'h0, 8'h0, 8'h0},
                         0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h00000001, 32'hFFFFFFFF, 12'h0, 8'h0, 8'h0, 8'h0},
                         0, none});
    dir_rows.push_back('{'{OP_SAMPLE, 32'h12345678, 32'h9ABCDEF0, 12'h0, 8'h0, 8'h0, 8'h0},
                         0, none});
    foreach (dir_rows[i]) send_beat(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

    // Index outside the register list must change nothing.
    write_reg(8'hFF, 16'hFFFF);
    write_reg(8'd2, 16'h1234);

    // Random phases across sizes, extremes included.
    phases.push_back('{16'd1, 16'd1, 40, 0, 0, 0});
    phases.push_back('{16'd4096, 16'd4096, 90, 1, 0, 0});
    phases.push_back('{16'd16, 16'd16, 70, 0, 1, 0});
    phases.push_back('{16'd0, 16'd5, 25, 0, 0, 0});
    phases.push_back('{16'd7, 16'd0, 25, 0, 0, 0});
    phases.push_back('{16'hFFFF, 16'd3, 50, 0, 0, 0});
    phases.push_back('{16'd3, 16'd4096, 50, 0, 0, 0});
    phases.push_back('{16'd4096, 16'd1, 50, 0, 0, 0});
    phases.push_back('{16'd2, 16'hFFFF, 50, 0, 0, 0});
    phases.push_back('{16'd64, 16'd64, 60, 0, 0, 1});
    foreach (phases[p]) begin
      write_reg(CFG_WIDTH, phases[p].w);
      write_reg(CFG_HEIGHT, phases[p].h);
      quiet = phases[p].calm;
      if (phases[p].hold) long_hold_req = 1'b1;
      for (int i = 0; i < phases[p].count; i++) begin
        if (phases[p].pause && i == phases[p].count / 2) drain_results();
        // Redraw samples that would touch a texel never written.
        rq = random_beat(25);
        while (!sample_ok(rq)) rq = random_beat(25);
        send_beat(rq, 0, none);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
